// ===== rtl/miller_rabin_prime_round_defines.svh =====
// assertion macros shared by the miller-rabin round rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef MILLER_RABIN_PRIME_ROUND_DEFINES_SVH
`define MILLER_RABIN_PRIME_ROUND_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define MRPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define MRPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mrpr_pkg.sv =====
// types and constants of the miller-rabin round block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrpr_pkg;

  // width of the candidate and witness fields on the ports
  localparam int unsigned FieldWidth = 32;

  // candidate that is composite though it is below five and above one
  localparam int unsigned SmallComposite = 4;

  // input transaction payload
  typedef struct packed {
    logic [FieldWidth-1:0] candidate;
    logic [FieldWidth-1:0] witness;
  } in_t;

  // output transaction payload
  typedef struct packed {
    logic probable_prime;
    logic bad_witness;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/mrpr_modmul.sv =====
// bit-serial modular multiplier: a * b mod n, one bit of b per cycle, lsb first
// needs a < n; b may be any value; uses miller_rabin_prime_round_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "miller_rabin_prime_round_defines.svh"

module mrpr_modmul #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic [W-1:0] n_i,
  output logic              done_o,
  output logic [W-1:0]      result_o
);

  logic [W-1:0] acc_q;
  logic [W-1:0] x_q;
  logic [W-1:0] y_q;
  logic [W-1:0] n_q;
  logic         busy_q;
  logic         done_q;
  logic [W-1:0] acc_d;
  logic [W-1:0] x_d;

  // p + q mod m for p, q < m: one add and one trial subtract
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] p, input logic [W-1:0] q,
                                           input logic [W-1:0] m);
    logic [W:0] sum;
    logic [W:0] dif;
    sum = {1'b0, p} + {1'b0, q};
    dif = sum - {1'b0, m};
    return dif[W] ? sum[W-1:0] : dif[W-1:0];
  endfunction

  // add the current multiple a*2^i into the sum when the b bit is set, and double that multiple, side by side
  always_comb begin
    acc_d = y_q[0] ? add_mod(acc_q, x_q, n_q) : acc_q;
    x_d   = add_mod(x_q, x_q, n_q);
  end

  // shift loop; ends as soon as no set bit of b is left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      n_q    <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i && (y_q == '0);
      if (start_i) begin
        acc_q  <= '0;
        x_q    <= a_i;
        y_q    <= b_i;
        n_q    <= n_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (y_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          acc_q <= acc_d;
          x_q   <= x_d;
          y_q   <= y_q >> 1;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

  // operands stay reduced while the loop runs
  `MRPR_ASSERT_NOW(a_mm_reduced, busy_q, (acc_q < n_q) && (x_q < n_q),
                   "modmul operand not reduced")
  // a new operation only starts on an idle unit
  `MRPR_ASSERT_NOW(a_mm_start_idle, start_i, !busy_q, "modmul started while busy")
  // a start always turns into a running loop
  `MRPR_ASSERT_NEXT(a_mm_start_busy, start_i, busy_q, "modmul did not start")

endmodule

`default_nettype wire

// ===== rtl/miller_rabin_prime_round.sv =====
// one miller-rabin strong probable-prime round per input transaction
// depends on mrpr_pkg, mrpr_modmul and miller_rabin_prime_round_defines.svh
//
// usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes a candidate and a witness;
//   only their low NUM_WIDTH bits count. out channel (out_valid_o/out_ready_i/
//   out_data_o) returns one verdict per input: probable_prime and bad_witness.
//   one transaction is worked on at a time; in_ready_o is high whenever no
//   transaction is in work, also while a finished verdict waits in the output
//   register. candidates 0 to 4 skip the test and go straight to the done
//   state. otherwise factors of two are stripped from candidate-1, then up to
//   2*NUM_WIDTH modular multiplies run on one bit-serial multiplier (one
//   multiplier bit per cycle); short exponents need fewer. a new transaction
//   is taken only once the last verdict has left the done state. reset clears
//   all control state; no verdict is pending after it. while the receiver
//   stalls, the verdict holds and the next transaction runs; its result waits
//   until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

`include "miller_rabin_prime_round_defines.svh"

module miller_rabin_prime_round #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mrpr_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mrpr_pkg::out_t     out_data_o
);

  localparam int unsigned W  = NUM_WIDTH;
  localparam int unsigned SW = $clog2(NUM_WIDTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STRIP,
    ST_RED_WAIT,
    ST_POW,
    ST_MUL_WAIT,
    ST_SQR_WAIT,
    ST_CHECK,
    ST_POST_WAIT,
    ST_DONE
  } state_e;

  state_e         state_q;
  logic [W-1:0]   n_q;
  logic [W-1:0]   w_q;
  logic [W-1:0]   e_q;
  logic [SW-1:0]  s_q;
  logic [W-1:0]   acc_q;
  logic [W-1:0]   base_q;
  logic           prime_q;
  logic           bad_q;
  logic           mm_start_q;
  logic [W-1:0]   mm_a_q;
  logic [W-1:0]   mm_b_q;
  logic           out_valid_q;
  mrpr_pkg::out_t out_q;

  logic [W-1:0]   n_in;
  logic [W-1:0]   w_in;
  logic [W-1:0]   n_m1;
  logic           mm_done;
  logic [W-1:0]   mm_result;
  logic           mm_waiting;

  // port fields trimmed to the working width
  assign n_in = in_data_i.candidate[W-1:0];
  assign w_in = in_data_i.witness[W-1:0];
  assign n_m1 = n_q - W'(1);

  // shared bit-serial multiplier
  mrpr_modmul #(
    .W(W)
  ) u_modmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start_q),
    .a_i      (mm_a_q),
    .b_i      (mm_b_q),
    .n_i      (n_q),
    .done_o   (mm_done),
    .result_o (mm_result)
  );

  // sequencer: small-candidate check, strip, reduce witness, square-and-multiply, squaring chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      w_q         <= '0;
      e_q         <= '0;
      s_q         <= '0;
      acc_q       <= '0;
      base_q      <= '0;
      prime_q     <= 1'b0;
      bad_q       <= 1'b0;
      mm_start_q  <= 1'b0;
      mm_a_q      <= '0;
      mm_b_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // output register drains while no new verdict is loaded
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            n_q   <= n_in;
            w_q   <= w_in;
            e_q   <= n_in - W'(1);
            s_q   <= '0;
            bad_q <= 1'b0;
            if ((n_in < W'(2)) || (n_in == W'(mrpr_pkg::SmallComposite))) begin
              prime_q <= 1'b0;
              state_q <= ST_DONE;
            end else if (n_in < W'(mrpr_pkg::SmallComposite)) begin
              prime_q <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              bad_q   <= (w_in < W'(2)) || (w_in > (n_in - W'(2)));
              state_q <= ST_STRIP;
            end
          end
        end
        // one factor of two per cycle
        ST_STRIP: begin
          if (!e_q[0]) begin
            e_q <= e_q >> 1;
            s_q <= s_q + SW'(1);
          end else begin
            mm_start_q <= 1'b1;
            mm_a_q     <= W'(1);
            mm_b_q     <= w_q;
            state_q    <= ST_RED_WAIT;
          end
        end
        // witness mod n comes out as 1 * witness
        ST_RED_WAIT: begin
          if (mm_done) begin
            base_q  <= mm_result;
            acc_q   <= W'(1);
            state_q <= ST_POW;
          end else begin
            mm_start_q <= 1'b0;
          end
        end
        ST_POW: begin
          if (e_q == '0) begin
            state_q <= ST_CHECK;
          end else if (e_q[0]) begin
            mm_start_q <= 1'b1;
            mm_a_q     <= acc_q;
            mm_b_q     <= base_q;
            state_q    <= ST_MUL_WAIT;
          end else begin
            mm_start_q <= 1'b1;
            mm_a_q     <= base_q;
            mm_b_q     <= base_q;
            state_q    <= ST_SQR_WAIT;
          end
        end
        // skip the base squaring after the top exponent bit
        ST_MUL_WAIT: begin
          if (mm_done) begin
            acc_q <= mm_result;
            if (e_q[W-1:1] == '0) begin
              e_q     <= '0;
              state_q <= ST_POW;
            end else begin
              mm_start_q <= 1'b1;
              mm_a_q     <= base_q;
              mm_b_q     <= base_q;
              state_q    <= ST_SQR_WAIT;
            end
          end else begin
            mm_start_q <= 1'b0;
          end
        end
        ST_SQR_WAIT: begin
          if (mm_done) begin
            base_q  <= mm_result;
            e_q     <= e_q >> 1;
            state_q <= ST_POW;
          end else begin
            mm_start_q <= 1'b0;
          end
        end
        // first look at witness^d, then up to s-1 squarings
        ST_CHECK: begin
          if ((acc_q == W'(1)) || (acc_q == n_m1)) begin
            prime_q <= 1'b1;
            state_q <= ST_DONE;
          end else if (s_q < SW'(2)) begin
            prime_q <= 1'b0;
            state_q <= ST_DONE;
          end else begin
            mm_start_q <= 1'b1;
            mm_a_q     <= acc_q;
            mm_b_q     <= acc_q;
            s_q        <= s_q - SW'(1);
            state_q    <= ST_POST_WAIT;
          end
        end
        ST_POST_WAIT: begin
          if (mm_done) begin
            acc_q <= mm_result;
            if (mm_result == W'(1)) begin
              prime_q <= 1'b0;
              state_q <= ST_DONE;
            end else if (mm_result == n_m1) begin
              prime_q <= 1'b1;
              state_q <= ST_DONE;
            end else if (s_q < SW'(2)) begin
              prime_q <= 1'b0;
              state_q <= ST_DONE;
            end else begin
              mm_start_q <= 1'b1;
              mm_a_q     <= mm_result;
              mm_b_q     <= mm_result;
              s_q        <= s_q - SW'(1);
            end
          end else begin
            mm_start_q <= 1'b0;
          end
        end
        // hand the verdict to the output register once it is free
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.probable_prime <= prime_q;
            out_q.bad_witness    <= bad_q;
            out_valid_q          <= 1'b1;
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          mm_start_q <= 1'b0;
          state_q    <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // states that wait for a multiplier result
  assign mm_waiting = (state_q == ST_RED_WAIT) || (state_q == ST_MUL_WAIT) ||
                      (state_q == ST_SQR_WAIT) || (state_q == ST_POST_WAIT);

  // multiplier finishes only while the sequencer waits for it
  `MRPR_ASSERT_NOW(a_done_in_wait, mm_done, mm_waiting, "multiplier result with no waiter")
  // square-and-multiply operands stay reduced mod n
  `MRPR_ASSERT_NOW(a_pow_reduced, state_q == ST_POW, (acc_q < n_q) && (base_q < n_q),
                   "exponentiation operand not reduced")
  // small candidates never flag the witness
  `MRPR_ASSERT_NOW(a_small_no_bad, (state_q == ST_DONE) && (n_q < W'(5)), !bad_q,
                   "bad witness on small candidate")

endmodule

`default_nettype wire
